### rtl/utt_pkg.sv
// Shared types and constants for the UTF-16/UTF-32 to UTF-8 transcoder.
`default_nettype none

package utt_pkg;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 2;   // byte count minus one

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Code point limits
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h010000;
    localparam logic [CP_W-1:0] CP_LIM_1B    = 21'h000080;
    localparam logic [CP_W-1:0] CP_LIM_2B    = 21'h000800;

    // Surrogate unit prefixes (top six bits of a 16-bit unit)
    localparam logic [5:0] SURR_HI_TAG = 6'b110110;
    localparam logic [5:0] SURR_LO_TAG = 6'b110111;

    // UTF-8 lead and continuation prefixes
    localparam logic [BYTE_W-1:0] LEAD_2B = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_3B = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4B = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_PF = 8'h80;
    localparam logic [5:0]        CONT_MASK = 6'h3F;

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_UNIT  = 2'd0,
        CMD_POINT = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // One character to encode: code point and byte count minus one
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
    } t_char;

endpackage

`default_nettype wire

### rtl/utt_front.sv
// Front end: accepts words, tracks the held surrogate, classifies characters.
`default_nettype none

module utt_front
    import utt_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [CMD_W-1:0] i_cmd,
    input  wire logic [CP_W-1:0] i_code_value,
    input  wire logic            i_queue_full,
    output logic                 o_push,
    output t_char                o_char
);

    logic [9:0]      r_held_bits, n_held_bits;
    logic            r_held_vld,  n_held_vld;
    logic            accept;
    logic            emit;
    logic [15:0]     unit;
    logic            is_hi, is_lo;
    logic [CP_W-1:0] cp;
    logic            cp_ok;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;
    assign unit    = i_code_value[15:0];
    assign is_hi   = (unit[15:10] == SURR_HI_TAG);
    assign is_lo   = (unit[15:10] == SURR_LO_TAG);
    assign cp_ok   = (i_code_value <= CP_MAX) &&
                     !((i_code_value >= CP_SURR_LO) && (i_code_value <= CP_SURR_HI));

    // Classify the word and update the held surrogate
    always_comb begin
        n_held_bits = r_held_bits;
        n_held_vld  = r_held_vld;
        emit        = 1'b0;
        cp          = '0;
        case (t_cmd'(i_cmd))
            CMD_UNIT: begin
                if (is_hi) begin
                    n_held_bits = unit[9:0];
                    n_held_vld  = 1'b1;
                end else if (is_lo) begin
                    if (r_held_vld) begin
                        cp          = {1'b0, r_held_bits, unit[9:0]} + CP_SUPP_BASE;
                        emit        = 1'b1;
                        n_held_bits = '0;
                        n_held_vld  = 1'b0;
                    end
                end else begin
                    cp          = {5'd0, unit};
                    emit        = 1'b1;
                    n_held_bits = '0;
                    n_held_vld  = 1'b0;
                end
            end
            CMD_POINT: begin
                cp   = i_code_value;
                emit = cp_ok;
            end
            CMD_CLEAR: begin
                n_held_bits = '0;
                n_held_vld  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Byte count of the encoding
    always_comb begin
        o_char.cp = cp;
        if (cp < CP_LIM_1B) begin
            o_char.len = 2'd0;
        end else if (cp < CP_LIM_2B) begin
            o_char.len = 2'd1;
        end else if (cp < CP_SUPP_BASE) begin
            o_char.len = 2'd2;
        end else begin
            o_char.len = 2'd3;
        end
    end

    assign o_push = accept && emit;

    // Held surrogate state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bits <= '0;
            r_held_vld  <= 1'b0;
        end else if (accept) begin
            r_held_bits <= n_held_bits;
            r_held_vld  <= n_held_vld;
        end
    end

    // A held surrogate always carries its bits; clearing zeroes them
    a_held_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_CLEAR) |=> (!r_held_vld && r_held_bits == '0))
        else $error("held surrogate not cleared");
    a_pair_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_held_vld && i_cmd == CMD_UNIT && is_lo) |=> !r_held_vld)
        else $error("surrogate pair left a held unit");
    a_supp_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_cmd == CMD_UNIT && is_lo) |-> (o_char.len == 2'd3))
        else $error("surrogate pair not a four-byte character");

endmodule

`default_nettype wire

### rtl/utt_queue.sv
// Short character queue between the front end and the byte serializer.
`default_nettype none

module utt_queue
    import utt_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_char i_char,
    input  wire logic  i_pop,
    output t_char      o_head,
    output logic       o_empty,
    output logic       o_full
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_char         r_mem [P_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_head  = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_char;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(P_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

### rtl/utt_back.sv
// Back end: splits each queued character into UTF-8 bytes, one word a cycle unless stalled.
`default_nettype none

module utt_back
    import utt_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_char        i_head,
    input  wire logic         i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [BYTE_W-1:0] o_utf8_byte,
    output logic              o_last_byte
);

    logic [LEN_W-1:0]  r_idx;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              load;
    logic              last;
    logic [LEN_W-1:0]  shift;
    logic [5:0]        chunk;
    logic [BYTE_W-1:0] n_byte;

    // Output register may take a new byte when empty or being drained
    assign load  = !i_empty && (!r_valid || !i_stall);
    assign last  = (r_idx == i_head.len);
    assign o_pop = load && last;
    assign shift = i_head.len - r_idx;

    // Six-bit group selected by the remaining byte count
    always_comb begin
        case (shift)
            2'd0:    chunk = i_head.cp[5:0];
            2'd1:    chunk = i_head.cp[11:6];
            2'd2:    chunk = i_head.cp[17:12];
            2'd3:    chunk = {3'd0, i_head.cp[20:18]};
            default: chunk = '0;
        endcase
    end

    // Lead byte or continuation byte
    always_comb begin
        if (r_idx != '0) begin
            n_byte = CONT_PF | {2'b00, chunk & CONT_MASK};
        end else begin
            case (i_head.len)
                2'd0:    n_byte = {1'b0, i_head.cp[6:0]};
                2'd1:    n_byte = LEAD_2B | {3'd0, i_head.cp[10:6]};
                2'd2:    n_byte = LEAD_3B | {4'd0, i_head.cp[15:12]};
                2'd3:    n_byte = LEAD_4B | {5'd0, i_head.cp[20:18]};
                default: n_byte = '0;
            endcase
        end
    end

    // Byte index and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= last ? '0 : r_idx + 1'b1;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_last <= last;
        end
    end

    assign o_valid     = r_valid;
    assign o_utf8_byte = r_byte;
    assign o_last_byte = r_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx <= i_head.len))
        else $error("byte index beyond character length");
    a_char_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |=> r_valid)
        else $error("gap inside a character");
    a_lead_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_stall && r_last) |=> (!r_valid || r_byte[7:6] != 2'b10))
        else $error("continuation byte starts a character");

endmodule

`default_nettype wire

### rtl/utf16_to_utf8_transcoder_unit.sv
// UTF-16/UTF-32 to UTF-8 transcoder: top level.
//
// Input channel (i_valid / o_stall): one word per accepted cycle, carrying
// i_cmd (UTF-16 code unit, UTF-32 code point, or clear) and i_code_value.
// High surrogates are held without output; a following low surrogate forms
// a supplementary character. Unpaired lows and invalid code points vanish.
// Output channel (o_valid / i_stall): one UTF-8 byte per word, o_last_byte
// set on the final byte of each character.
// The first byte of a character passes the queue, then the output register.
// One output byte per cycle while the receiver does not stall, set by the
// single-byte output register; supplementary characters take four bytes.
// A short character queue decouples the classifier from the serializer, so
// input keeps flowing while bytes drain; o_stall rises only when it is full.
// When the receiver stalls, the output word holds and the queue fills.
// Reset (synchronous, active low) empties the queue, drops any output word
// and forgets the held surrogate.
`default_nettype none

module utf16_to_utf8_transcoder_unit
    import utt_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [CMD_W-1:0] i_cmd,
    input  wire logic [CP_W-1:0]  i_code_value,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [BYTE_W-1:0]     o_utf8_byte,
    output logic                  o_last_byte
);

    logic  push, pop, empty, full;
    t_char push_char, head;

    utt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_code_value (i_code_value),
        .i_queue_full (full),
        .o_push       (push),
        .o_char       (push_char)
    );

    utt_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_char  (push_char),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    utt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_utf8_byte (o_utf8_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the UTF-16/UTF-32 to UTF-8 transcoder.
`default_nettype none

module tb;
    import utt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;   // unused command, must be ignored
    localparam int RAND_ITEMS  = 78;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    // Up to four bytes of one character, first byte in b[0]
    typedef struct packed {
        logic [2:0]       n;
        logic [3:0][7:0]  b;
    } t_utf8_seq;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_utf8_word;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [CP_W-1:0]  val;
        logic             typed;
        t_utf8_seq        want;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [CMD_W-1:0]     i_cmd = CMD_UNIT;
    logic [CP_W-1:0]      i_code_value = '0;
    logic                 i_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [BYTE_W-1:0]    o_utf8_byte;
    logic                 o_last_byte;

    // Predictor state: pending high surrogate
    logic [9:0]  held_high = '0;
    logic        held_ok = 1'b0;

    t_utf8_word  utf8_due[$];
    t_utf8_word  due_word;
    t_stim_row   stim_rows[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;
    bit          holding = 1'b0;

    utf16_to_utf8_transcoder_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_code_value (i_code_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_utf8_byte  (o_utf8_byte),
        .o_last_byte  (o_last_byte)
    );

    initial begin
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    // UTF-8 encoding of one code point; invalid points give no bytes
    function automatic t_utf8_seq encode_utf8(input logic [CP_W-1:0] cp);
        t_utf8_seq s;
        s = '0;
        if (cp > 21'h10FFFF || (cp >= 21'h00D800 && cp <= 21'h00DFFF)) begin
            s.n = 3'd0;
        end else if (cp < 21'h000080) begin
            s.n = 3'd1;
            s.b[0] = cp[7:0];
        end else if (cp < 21'h000800) begin
            s.n = 3'd2;
            s.b[0] = 8'hC0 | {3'b0, cp[10:6]};
            s.b[1] = 8'h80 | {2'b0, cp[5:0]};
        end else if (cp < 21'h010000) begin
            s.n = 3'd3;
            s.b[0] = 8'hE0 | {4'b0, cp[15:12]};
            s.b[1] = 8'h80 | {2'b0, cp[11:6]};
            s.b[2] = 8'h80 | {2'b0, cp[5:0]};
        end else begin
            s.n = 3'd4;
            s.b[0] = 8'hF0 | {5'b0, cp[20:18]};
            s.b[1] = 8'h80 | {2'b0, cp[17:12]};
            s.b[2] = 8'h80 | {2'b0, cp[11:6]};
            s.b[3] = 8'h80 | {2'b0, cp[5:0]};
        end
        return s;
    endfunction

    // One accepted word: update surrogate state, return the bytes it yields
    function automatic t_utf8_seq transcode_word(input logic [CMD_W-1:0] cmd,
                                                 input logic [CP_W-1:0] val);
        t_utf8_seq  s;
        logic [15:0] unit;
        logic [CP_W-1:0] cp;
        s = '0;
        unit = val[15:0];
        case (cmd)
            CMD_UNIT: begin
                if (unit[15:10] == 6'b110110) begin
                    held_high = unit[9:0];
                    held_ok = 1'b1;
                end else if (unit[15:10] == 6'b110111) begin
                    // lone low surrogate leaves everything as it was
                    if (held_ok) begin
                        cp = 21'h010000 + {1'b0, held_high, unit[9:0]};
                        held_high = '0;
                        held_ok = 1'b0;
                        s = encode_utf8(cp);
                    end
                end else begin
                    held_high = '0;
                    held_ok = 1'b0;
                    s = encode_utf8({5'b0, unit});
                end
            end
            CMD_POINT: s = encode_utf8(val);
            CMD_CLEAR: begin
                held_high = '0;
                held_ok = 1'b0;
            end
            default: s = '0;
        endcase
        return s;
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [4:0] rand_upper();
        if ($urandom_range(0, 4) == 0) return 5'($urandom);
        return 5'd0;
    endfunction

    function automatic logic [15:0] rand_bmp();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [CP_W-1:0] rand_point();
        if ($urandom_range(0, 2) == 0) return 21'($urandom_range(21'h010000, 21'h10FFFF));
        return {5'b0, rand_bmp()};
    endfunction

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [CP_W-1:0] val,
                           input bit typed, input int n, input logic [7:0] b0,
                           input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3);
        t_stim_row r;
        r.cmd = cmd;
        r.val = val;
        r.typed = typed;
        r.want.n = 3'(n);
        r.want.b[0] = b0;
        r.want.b[1] = b1;
        r.want.b[2] = b2;
        r.want.b[3] = b3;
        stim_rows.push_back(r);
    endtask

    // Offer one word, wait for it to be taken, queue the bytes it should give
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CP_W-1:0] val,
                             input bit typed, input t_utf8_seq want, output bit counted);
        int gap;
        t_utf8_seq s;
        logic [10:0] prev;
        gap = holding ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_code_value <= val;
        do @(posedge i_clk); while (o_stall);
        prev = {held_ok, held_high};
        s = transcode_word(cmd, val);
        if (typed) s = want;
        for (int k = 0; k < s.n; k++) begin
            utf8_due.push_back('{data: s.b[k], last: (k == s.n - 1)});
        end
        counted = (s.n != 0) || (prev != {held_ok, held_high});
    endtask

    // Output checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (utf8_due.size() == 0) begin
                $error("unexpected word: utf8_byte=%h last_byte=%b", o_utf8_byte, o_last_byte);
                mismatches++;
            end else begin
                due_word = utf8_due.pop_front();
                if (o_utf8_byte !== due_word.data) begin
                    $error("utf8_byte: expected %h, got %h", due_word.data, o_utf8_byte);
                    mismatches++;
                end
                if (o_last_byte !== due_word.last) begin
                    $error("last_byte: expected %b, got %b", due_word.last, o_last_byte);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to fill the block
    initial begin
        int free_len;
        int stall_len;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                holding = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holding = 1'b0;
            end
            free_len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 12);
            i_stall <= 1'b0;
            repeat (free_len) @(posedge i_clk);
            stall_len = pick_gap();
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    // Sender: directed table, then random sequences
    initial begin
        t_utf8_seq none;
        logic [CP_W-1:0] v;
        int scen;
        int done_items;
        bit c;
        none = '0;

        // extremes of the one-, two- and three-byte encoding lengths
        add_row(CMD_UNIT,  21'h000000, 1, 1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_UNIT,  21'h00007F, 1, 1, 8'h7F, 8'h00, 8'h00, 8'h00);
        add_row(CMD_UNIT,  21'h000080, 1, 2, 8'hC2, 8'h80, 8'h00, 8'h00);
        add_row(CMD_UNIT,  21'h0007FF, 1, 2, 8'hDF, 8'hBF, 8'h00, 8'h00);
        add_row(CMD_UNIT,  21'h000800, 1, 3, 8'hE0, 8'hA0, 8'h80, 8'h00);
        add_row(CMD_UNIT,  21'h00FFFF, 1, 3, 8'hEF, 8'hBF, 8'hBF, 8'h00);
        // pairing, lone low, replaced high
        add_row(CMD_UNIT,  21'h00D800, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_UNIT,  21'h00DC00, 1, 4, 8'hF0, 8'h90, 8'h80, 8'h80);
        add_row(CMD_UNIT,  21'h00DFFF, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_UNIT,  21'h00DBFF, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_UNIT,  21'h00D800, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_UNIT,  21'h00DFFF, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        // clear drops the held high
        add_row(CMD_UNIT,  21'h00DBFF, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_CLEAR, 21'h1FFFFF, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_UNIT,  21'h00DC00, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        // unit with upper bits set: only low 16 bits count
        add_row(CMD_UNIT,  21'h1F0041, 1, 1, 8'h41, 8'h00, 8'h00, 8'h00);
        // code points: top valid, out of range, surrogate range
        add_row(CMD_POINT, 21'h10FFFF, 1, 4, 8'hF4, 8'h8F, 8'hBF, 8'hBF);
        add_row(CMD_POINT, 21'h110000, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_POINT, 21'h1FFFFF, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_POINT, 21'h00D800, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_POINT, 21'h00DFFF, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        // point and unused command leave a held high in place
        add_row(CMD_UNIT,  21'h00DBFF, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_POINT, 21'h01F600, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SPARE, 21'h1FFFFF, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(CMD_UNIT,  21'h00DFFF, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            send_word(stim_rows[i].cmd, stim_rows[i].val, stim_rows[i].typed,
                      stim_rows[i].want, c);
        end

        hold_req = 1'b1;
        done_items = 0;
        while (done_items < RAND_ITEMS) begin
            scen = $urandom_range(0, 99);
            if (scen < 30) begin
                // well-formed pair, now and then a code point in between
                v = {rand_upper(), 6'b110110, 10'($urandom)};
                send_word(CMD_UNIT, v, 0, none, c);
                done_items += c;
                if ($urandom_range(0, 9) == 0) begin
                    send_word(CMD_POINT, rand_point(), 0, none, c);
                    done_items += c;
                end
                v = {rand_upper(), 6'b110111, 10'($urandom)};
                send_word(CMD_UNIT, v, 0, none, c);
            end else if (scen < 50) begin
                send_word(CMD_UNIT, {rand_upper(), rand_bmp()}, 0, none, c);
            end else if (scen < 75) begin
                send_word(CMD_POINT, rand_point(), 0, none, c);
            end else if (scen < 83) begin
                if ($urandom_range(0, 1) == 0) v = 21'($urandom_range(21'h110000, 21'h1FFFFF));
                else v = 21'($urandom_range(21'h00D800, 21'h00DFFF));
                send_word(CMD_POINT, v, 0, none, c);
            end else if (scen < 88) begin
                send_word(CMD_CLEAR, 21'($urandom), 0, none, c);
            end else if (scen < 93) begin
                // high left unpaired, broken by a plain unit
                v = {rand_upper(), 6'b110110, 10'($urandom)};
                send_word(CMD_UNIT, v, 0, none, c);
                done_items += c;
                send_word(CMD_UNIT, {rand_upper(), rand_bmp()}, 0, none, c);
            end else if (scen < 97) begin
                send_word(2'($urandom_range(0, 3)), 21'($urandom), 0, none, c);
            end else begin
                // high, clear, then a low that must vanish
                v = {rand_upper(), 6'b110110, 10'($urandom)};
                send_word(CMD_UNIT, v, 0, none, c);
                done_items += c;
                send_word(CMD_CLEAR, 21'($urandom), 0, none, c);
                done_items += c;
                v = {rand_upper(), 6'b110111, 10'($urandom)};
                send_word(CMD_UNIT, v, 0, none, c);
            end
            done_items += c;
        end
        i_valid <= 1'b0;

        while (utf8_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/utt_pkg.sv
rtl/utt_front.sv
rtl/utt_queue.sv
rtl/utt_back.sv
rtl/utf16_to_utf8_transcoder_unit.sv
bench/tb.sv
